FILE: rtl/fdtd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fdtd_pkg;

  localparam int unsigned COORD_W   = 5;
  localparam int unsigned NODES_W   = 6;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned ADDR_W    = 3 * COORD_W;
  localparam int unsigned N_BANKS   = 8;
  localparam int unsigned MAX_NODES = 32;

  // commands
  localparam logic [2:0] CMD_WRITE = 3'd0;
  localparam logic [2:0] CMD_READ  = 3'd1;
  localparam logic [2:0] CMD_UPD_E = 3'd2;
  localparam logic [2:0] CMD_UPD_B = 3'd3;
  localparam logic [2:0] CMD_BOUND = 3'd4;

  // storage banks (quantity codes)
  localparam logic [2:0] Q_EX   = 3'd0;
  localparam logic [2:0] Q_BX   = 3'd3;
  localparam logic [2:0] Q_IEPS = 3'd6;
  localparam logic [2:0] Q_IMU  = 3'd7;

  // configuration register indexes
  localparam logic [2:0] CFG_NODES_X = 3'd0;
  localparam logic [2:0] CFG_NODES_Y = 3'd1;
  localparam logic [2:0] CFG_NODES_Z = 3'd2;
  localparam logic [2:0] CFG_ISP_X   = 3'd3;
  localparam logic [2:0] CFG_ISP_Y   = 3'd4;
  localparam logic [2:0] CFG_ISP_Z   = 3'd5;

  localparam logic [VAL_W-1:0] ONE_Q16 = 32'h0001_0000;

  typedef logic [2:0][COORD_W-1:0] xyz_t;     // [0]=x [1]=y [2]=z
  typedef logic [2:0][NODES_W-1:0] nodes_t;

  typedef struct packed {
    logic [2:0]        command;
    logic [2:0]        quantity;
    logic [4:0]        cell_x;
    logic [4:0]        cell_y;
    logic [4:0]        cell_z;
    logic signed [31:0] write_value;
    logic [31:0]       step_size;
  } in_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic              status;
  } out_t;

  // datapath operation of the cycle
  typedef enum logic [19:0] {
    ST_NOP   = 20'h00001,
    ST_CLEAR = 20'h00002,
    ST_SWR   = 20'h00004,
    ST_SRD   = 20'h00008,
    ST_SCAP  = 20'h00010,
    ST_RDA   = 20'h00020,
    ST_RDB   = 20'h00040,
    ST_RDT   = 20'h00080,
    ST_M1    = 20'h00100,
    ST_M2    = 20'h00200,
    ST_R2    = 20'h00400,
    ST_CURL  = 20'h00800,
    ST_M3    = 20'h01000,
    ST_R3    = 20'h02000,
    ST_M4    = 20'h04000,
    ST_R4    = 20'h08000,
    ST_WR    = 20'h10000,
    ST_BRD   = 20'h20000,
    ST_BWL   = 20'h40000,
    ST_BWH   = 20'h80000
  } step_e;

  typedef struct packed {
    step_e      step;
    logic [1:0] comp;
    logic [1:0] pass;
    xyz_t       ctr;
    logic       load_in;
    logic       load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       in_range;
    logic       out_busy;
    nodes_t     nodes;
  } dp_sts_t;

endpackage

`default_nettype wire

FILE: rtl/fdtd_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module fdtd_ram #(
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned ADDR_W = 15
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_a_i,
  input  wire logic [ADDR_W-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]  rdata_a_o,
  output logic      [WIDTH-1:0]  rdata_b_o
);

  logic [WIDTH-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered reads, held while re_i is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem[raddr_a_i];
      rdata_b_o <= mem[raddr_b_i];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/fdtd_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module fdtd_dp (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire fdtd_pkg::in_t   in_data_i,
  input  wire fdtd_pkg::dp_cmd_t cmd_i,
  output fdtd_pkg::dp_sts_t    sts_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output fdtd_pkg::out_t       out_data_o,
  input  wire logic            cfg_valid_i,
  input  wire logic [2:0]      cfg_index_i,
  input  wire logic [31:0]     cfg_data_i
);

  import fdtd_pkg::*;

  // ---- arithmetic helpers
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) sat_add = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    else sat_add = s[31:0];
  endfunction

  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic [32:0] s;
    s = {a[31], a} - {b[31], b};
    if (s[32] != s[31]) sat_sub = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    else sat_sub = s[31:0];
  endfunction

  function automatic logic signed [31:0] sat_neg(input logic signed [31:0] a);
    if (a == 32'sh8000_0000) sat_neg = 32'sh7FFF_FFFF;
    else sat_neg = 32'sd0 - a;
  endfunction

  function automatic logic [31:0] mag(input logic signed [31:0] a);
    mag = a[31] ? (32'd0 - a) : a;
  endfunction

  // round half away from zero on the magnitude, drop 16 fraction bits, saturate
  function automatic logic signed [31:0] rnd(input logic [63:0] p, input logic ng);
    logic [64:0] s;
    logic [48:0] r;
    logic [48:0] lim;
    s   = {1'b0, p} + 65'h8000;
    r   = s[64:16];
    lim = ng ? 49'h0_8000_0000 : 49'h0_7FFF_FFFF;
    if (r > lim) r = lim;
    rnd = ng ? (32'd0 - r[31:0]) : r[31:0];
  endfunction

  function automatic logic [1:0] inc3(input logic [1:0] v);
    inc3 = (v == 2'd2) ? 2'd0 : v + 2'd1;
  endfunction

  function automatic logic [ADDR_W-1:0] to_addr(input xyz_t v);
    to_addr = {v[0], v[1], v[2]};
  endfunction

  function automatic xyz_t set_ax(input xyz_t v, input logic [1:0] ax,
                                  input logic [COORD_W-1:0] val);
    xyz_t r;
    r = v;
    r[ax] = val;
    set_ax = r;
  endfunction

  function automatic logic [NODES_W-1:0] eff(input logic [NODES_W-1:0] n);
    if (n < 6'd3) eff = 6'd3;
    else if (n > 6'(MAX_NODES)) eff = 6'(MAX_NODES);
    else eff = n;
  endfunction

  // ---- configuration registers
  logic [NODES_W-1:0] nx_q, ny_q, nz_q;
  logic [31:0]        spx_q, spy_q, spz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nx_q  <= 6'(MAX_NODES);
      ny_q  <= 6'(MAX_NODES);
      nz_q  <= 6'(MAX_NODES);
      spx_q <= ONE_Q16;
      spy_q <= ONE_Q16;
      spz_q <= ONE_Q16;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_NODES_X: nx_q  <= cfg_data_i[NODES_W-1:0];
        CFG_NODES_Y: ny_q  <= cfg_data_i[NODES_W-1:0];
        CFG_NODES_Z: nz_q  <= cfg_data_i[NODES_W-1:0];
        CFG_ISP_X:   spx_q <= cfg_data_i;
        CFG_ISP_Y:   spy_q <= cfg_data_i;
        CFG_ISP_Z:   spz_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  nodes_t            nn;
  logic [2:0][31:0]  sp;
  assign nn = {eff(nz_q), eff(ny_q), eff(nx_q)};
  assign sp = {spz_q, spy_q, spx_q};

  // ---- captured request
  in_t  in_q;
  xyz_t inc;
  logic in_range, is_e;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) in_q <= in_data_i;
  end

  assign inc      = {in_q.cell_z, in_q.cell_y, in_q.cell_x};
  assign in_range = ({1'b0, in_q.cell_x} < nn[0]) && ({1'b0, in_q.cell_y} < nn[1]) &&
                    ({1'b0, in_q.cell_z} < nn[2]);
  assign is_e     = (in_q.command == CMD_UPD_E);

  // ---- working registers of the update pipeline
  logic signed [31:0] d1_q, d2_q, tgt_q, inv_q, m1_q, acc_q;

  // ---- operand selection
  logic [1:0] c, fa, fb, axa, axb;
  logic [2:0] fbase, tbank;
  xyz_t       ctr;
  logic [NODES_W-1:0] np_m1, np_m2;

  assign c     = cmd_i.comp;
  assign ctr   = cmd_i.ctr;
  assign axa   = inc3(c);
  assign axb   = inc3(inc3(c));
  assign fa    = axb;
  assign fb    = axa;
  assign fbase = is_e ? Q_BX : Q_EX;
  assign tbank = (is_e ? Q_EX : Q_BX) + {1'b0, c};
  assign np_m1 = nn[cmd_i.pass] - 6'd1;
  assign np_m2 = nn[cmd_i.pass] - 6'd2;

  function automatic xyz_t nbr(input xyz_t v, input logic [1:0] ax, input logic dn);
    xyz_t r;
    r = v;
    r[ax] = dn ? v[ax] - 5'd1 : v[ax] + 5'd1;
    nbr = r;
  endfunction

  logic               re, we, clr;
  logic [2:0]         bank_a, bank_b, wbank;
  logic [ADDR_W-1:0]  addr_a, addr_b, waddr;
  logic signed [31:0] wdata, ram_a, ram_b;

  always_comb begin
    re = 1'b0;
    we = 1'b0;
    clr = 1'b0;
    bank_a = tbank;
    bank_b = tbank;
    addr_a = to_addr(ctr);
    addr_b = to_addr(ctr);
    wbank = tbank;
    waddr = to_addr(ctr);
    wdata = is_e ? sat_add(acc_q, 32'sd0) : 32'sd0;
    case (cmd_i.step)
      ST_CLEAR: clr = 1'b1;
      ST_SWR: begin
        we = 1'b1;
        wbank = in_q.quantity;
        waddr = to_addr(inc);
        wdata = in_q.write_value;
      end
      ST_SRD: begin
        re = 1'b1;
        bank_a = in_q.quantity;
        addr_a = to_addr(inc);
      end
      ST_RDA: begin
        re = 1'b1;
        bank_a = fbase + {1'b0, fa};
        bank_b = bank_a;
        addr_a = is_e ? to_addr(ctr) : to_addr(nbr(ctr, axa, 1'b0));
        addr_b = is_e ? to_addr(nbr(ctr, axa, 1'b1)) : to_addr(ctr);
      end
      ST_RDB: begin
        re = 1'b1;
        bank_a = fbase + {1'b0, fb};
        bank_b = bank_a;
        addr_a = is_e ? to_addr(ctr) : to_addr(nbr(ctr, axb, 1'b0));
        addr_b = is_e ? to_addr(nbr(ctr, axb, 1'b1)) : to_addr(ctr);
      end
      ST_RDT: begin
        re = 1'b1;
        bank_a = tbank;
        bank_b = is_e ? Q_IEPS : Q_IMU;
      end
      ST_WR: begin
        we = 1'b1;
        wdata = is_e ? sat_add(tgt_q, acc_q) : sat_sub(tgt_q, acc_q);
      end
      ST_BRD: begin
        re = 1'b1;
        bank_a = {1'b0, c};
        bank_b = {1'b0, c};
        addr_a = to_addr(set_ax(ctr, cmd_i.pass, 5'd1));
        addr_b = to_addr(set_ax(ctr, cmd_i.pass, np_m2[COORD_W-1:0]));
      end
      ST_BWL: begin
        we = 1'b1;
        wbank = {1'b0, c};
        waddr = to_addr(set_ax(ctr, cmd_i.pass, 5'd0));
        wdata = sat_neg(ram_a);
      end
      ST_BWH: begin
        we = 1'b1;
        wbank = {1'b0, c};
        waddr = to_addr(set_ax(ctr, cmd_i.pass, np_m1[COORD_W-1:0]));
        wdata = sat_neg(ram_b);
      end
      default: ;
    endcase
  end

  // ---- grid storage: one bank per quantity, shared addresses
  logic [2:0] sel_a_q, sel_b_q;
  logic [N_BANKS-1:0][31:0] rd_a, rd_b;

  for (genvar b = 0; b < N_BANKS; b++) begin : g_bank
    localparam logic [31:0] INIT = (b >= 6) ? ONE_Q16 : 32'd0;
    logic bwe;
    assign bwe = clr || (we && (wbank == 3'(b)));
    fdtd_ram #(.WIDTH(VAL_W), .ADDR_W(ADDR_W)) u_ram (
      .clk_i     (clk_i),
      .we_i      (bwe),
      .waddr_i   (waddr),
      .wdata_i   (clr ? INIT : wdata),
      .re_i      (re),
      .raddr_a_i (addr_a),
      .raddr_b_i (addr_b),
      .rdata_a_o (rd_a[b]),
      .rdata_b_o (rd_b[b])
    );
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      sel_a_q <= bank_a;
      sel_b_q <= bank_b;
    end
  end

  assign ram_a = rd_a[sel_a_q];
  assign ram_b = rd_b[sel_b_q];

  // ---- shared multiplier
  logic [63:0]        prod_q;
  logic               neg_q;
  logic [31:0]        mop_a, mop_b;
  logic               mneg;

  always_comb begin
    mop_a = mag(d1_q);
    mop_b = sp[axa];
    mneg  = d1_q[31] && (sp[axa] != 32'd0);
    case (cmd_i.step)
      ST_M2: begin
        mop_a = mag(d2_q);
        mop_b = sp[axb];
        mneg  = d2_q[31] && (sp[axb] != 32'd0);
      end
      ST_M3: begin
        mop_a = mag(acc_q);
        mop_b = in_q.step_size;
        mneg  = acc_q[31] && (in_q.step_size != 32'd0);
      end
      ST_M4: begin
        mop_a = mag(acc_q);
        mop_b = mag(inv_q);
        mneg  = acc_q[31] != inv_q[31];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.step)
      ST_RDB:  d1_q <= sat_sub(ram_a, ram_b);
      ST_RDT:  d2_q <= sat_sub(ram_a, ram_b);
      ST_M1: begin
        tgt_q  <= ram_a;
        inv_q  <= ram_b;
        prod_q <= 64'(mop_a) * 64'(mop_b);
        neg_q  <= mneg;
      end
      ST_M2: begin
        m1_q   <= rnd(prod_q, neg_q);
        prod_q <= 64'(mop_a) * 64'(mop_b);
        neg_q  <= mneg;
      end
      ST_M3, ST_M4: begin
        prod_q <= 64'(mop_a) * 64'(mop_b);
        neg_q  <= mneg;
      end
      ST_R2, ST_R3, ST_R4: acc_q <= rnd(prod_q, neg_q);
      ST_CURL: acc_q <= sat_sub(m1_q, acc_q);
      default: ;
    endcase
  end

  // ---- result and output register
  logic signed [31:0] res_q;
  logic               out_valid_q;
  out_t               out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) res_q <= 32'sd0;
    else if (cmd_i.step == ST_SCAP) res_q <= ram_a;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.read_value <= res_q;
      out_q.status     <= ((in_q.command == CMD_WRITE) || (in_q.command == CMD_READ)) &&
                          !in_range;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign sts_o.cmd      = in_q.command;
  assign sts_o.in_range = in_range;
  assign sts_o.out_busy = out_valid_q && !out_ready_i;
  assign sts_o.nodes    = nn;

endmodule

`default_nettype wire

FILE: rtl/fdtd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module fdtd_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire fdtd_pkg::dp_sts_t sts_i,
  output fdtd_pkg::dp_cmd_t      cmd_o
);

  import fdtd_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_DEC   = 6'b000100,
    S_RDW   = 6'b001000,
    S_RUN   = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e     state_q, state_d;
  step_e      step_q, step_d;
  logic [1:0] comp_q, comp_d, pass_q, pass_d;
  xyz_t       ctr_q, ctr_d;

  // loop bounds per axis
  logic              is_e, sweep;
  xyz_t              lo, hi, nxt;
  logic              carry;
  logic [NODES_W-1:0] nm1, nm2;

  assign is_e  = (sts_i.cmd == CMD_UPD_E);
  assign sweep = is_e || (sts_i.cmd == CMD_UPD_B);

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      nm1 = sts_i.nodes[a] - 6'd1;
      nm2 = sts_i.nodes[a] - 6'd2;
      if (sweep) begin
        lo[a] = is_e ? 5'd1 : 5'd0;
        hi[a] = nm2[COORD_W-1:0];
      end else begin
        lo[a] = 5'd0;
        hi[a] = (pass_q == 2'(a)) ? 5'd0 : nm1[COORD_W-1:0];
      end
    end
  end

  // next node, z innermost
  always_comb begin
    nxt   = ctr_q;
    carry = 1'b1;
    for (int a = 2; a >= 0; a--) begin
      if (carry) begin
        if (ctr_q[a] == hi[a]) begin
          nxt[a] = lo[a];
        end else begin
          nxt[a] = ctr_q[a] + 5'd1;
          carry  = 1'b0;
        end
      end
    end
  end

  // sequencing
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    comp_d  = comp_q;
    pass_d  = pass_q;
    ctr_d   = ctr_q;
    in_ready_o     = 1'b0;
    cmd_o.step     = ST_NOP;
    cmd_o.comp     = comp_q;
    cmd_o.pass     = pass_q;
    cmd_o.ctr      = ctr_q;
    cmd_o.load_in  = 1'b0;
    cmd_o.load_out = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.step = ST_CLEAR;
        ctr_d = ctr_q + 15'd1;
        if (ctr_q == '1) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        comp_d = 2'd0;
        pass_d = 2'd0;
        ctr_d  = lo;
        case (sts_i.cmd)
          CMD_WRITE: begin
            if (sts_i.in_range) cmd_o.step = ST_SWR;
            state_d = S_DONE;
          end
          CMD_READ: begin
            if (sts_i.in_range) begin
              cmd_o.step = ST_SRD;
              state_d = S_RDW;
            end else begin
              state_d = S_DONE;
            end
          end
          CMD_UPD_E, CMD_UPD_B: begin
            step_d  = ST_RDA;
            state_d = S_RUN;
          end
          CMD_BOUND: begin
            ctr_d   = '0;
            step_d  = ST_BRD;
            state_d = S_RUN;
          end
          default: state_d = S_DONE;
        endcase
      end
      S_RDW: begin
        cmd_o.step = ST_SCAP;
        state_d = S_DONE;
      end
      S_RUN: begin
        cmd_o.step = step_q;
        case (step_q)
          ST_RDA:  step_d = ST_RDB;
          ST_RDB:  step_d = ST_RDT;
          ST_RDT:  step_d = ST_M1;
          ST_M1:   step_d = ST_M2;
          ST_M2:   step_d = ST_R2;
          ST_R2:   step_d = ST_CURL;
          ST_CURL: step_d = ST_M3;
          ST_M3:   step_d = ST_R3;
          ST_R3:   step_d = ST_M4;
          ST_M4:   step_d = ST_R4;
          ST_R4:   step_d = ST_WR;
          ST_WR: begin
            step_d = ST_RDA;
            if (comp_q != 2'd2) begin
              comp_d = comp_q + 2'd1;
            end else begin
              comp_d = 2'd0;
              ctr_d  = nxt;
              if (carry) state_d = S_DONE;
            end
          end
          ST_BRD:  step_d = ST_BWL;
          ST_BWL:  step_d = ST_BWH;
          ST_BWH: begin
            step_d = ST_BRD;
            ctr_d  = nxt;
            if (carry) begin
              if (comp_q != 2'd2) begin
                comp_d = comp_q + 2'd1;
              end else if (pass_q != 2'd2) begin
                comp_d = 2'd0;
                pass_d = pass_q + 2'd1;
              end else begin
                state_d = S_DONE;
              end
            end
          end
          default: state_d = S_DONE;
        endcase
      end
      S_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      step_q  <= ST_NOP;
      comp_q  <= 2'd0;
      pass_q  <= 2'd0;
      ctr_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      comp_q  <= comp_d;
      pass_q  <= pass_d;
      ctr_q   <= ctr_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/fdtd_yee_field_update.sv
// E and B sweeps update the three components of each node in turn through one shared
// 32x32 multiplier and the single grid write port; boundary works on one mirrored node
// pair at a time, over 3 planes x 3 components. One request is in work at a time.
// Reset: configuration returns to 32 nodes and unit spacings; the grid is then cleared
// (fields to zero, materials to 1.0) before the first request is taken.
`timescale 1ns / 1ps
`default_nettype none

module fdtd_yee_field_update (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire fdtd_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output fdtd_pkg::out_t      out_data_o,
  input  wire logic           cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire logic [2:0]     cfg_index_i,
  input  wire logic [31:0]    cfg_data_i
);

  import fdtd_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // registers are always writable
  assign cfg_ready_o = 1'b1;

  fdtd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  fdtd_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (dp_cmd),
    .sts_o       (dp_sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // a result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.load_out |-> !(out_valid_o && !out_ready_i))
    else $error("result register overwritten");

  // capture, result load and datapath work never coincide
  a_cmd_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({dp_cmd.load_in, dp_cmd.load_out, dp_cmd.step != ST_NOP}))
    else $error("conflicting datapath commands");

  // after a request is taken the block is busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted twice in a row");

endmodule

`default_nettype wire
